/* hw/rtl/rrqs_pkg.sv */
// Package for the round-robin quantum scheduler.
// Holds status and command codes, field widths and reset defaults.
// No dependencies.
package rrqs_pkg;

  localparam int NUM_SLOTS_DEFAULT = 16;
  localparam int PID_WIDTH_DEFAULT = 16;

  localparam int QUANTUM_WIDTH = 4;
  localparam int COUNT_WIDTH   = 4;
  localparam int STATUS_WIDTH  = 2;
  localparam int SLOT_OUT_WIDTH = 4;
  localparam int PID_OUT_WIDTH  = 16;
  localparam int REQ_WIDTH      = 8;

  localparam logic [QUANTUM_WIDTH-1:0] MAX_QUANTUM_RESET = 4'd10;
  localparam logic [QUANTUM_WIDTH-1:0] IDLE_QUANTUM      = 4'd1;
  localparam logic [COUNT_WIDTH-1:0]   COUNT_TOP         = 4'd15;

  localparam logic [STATUS_WIDTH-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_NONE = 2'd2;

  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

endpackage

/* hw/rtl/rrqs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the scheduler slot table. No dependencies.
module rrqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/round_robin_quantum_scheduler.sv */
// Top level of the round-robin quantum scheduler.
// Depends on rrqs_pkg and rrqs_ram.

// A command is taken when start is high and busy is low; exactly one result
// word follows, shown for one cycle with out_valid high, and the receiver
// cannot stall it. A create looks for the first free slot by checking one
// slot per cycle, and answers table-full if none is free. A tick with no
// task yet answers without a RAM read; a tick that keeps the current task
// does one slot-table RAM read; a tick that moves on also runs the
// one-slot-per-cycle round-robin scan plus a second RAM read of the chosen
// slot. The result appears on the cycle after the last step. max_quantum is
// written through cfg_wr_en/cfg_wr_data; the user must write it only while
// the block is idle, which the block itself does not enforce.
module round_robin_quantum_scheduler #(
  parameter int NUM_SLOTS = rrqs_pkg::NUM_SLOTS_DEFAULT,
  parameter int PID_WIDTH = rrqs_pkg::PID_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_cmd,
  input  logic [rrqs_pkg::REQ_WIDTH-1:0]        in_time_slot,
  output logic                                  out_valid,
  output logic [rrqs_pkg::STATUS_WIDTH-1:0]     out_status,
  output logic [rrqs_pkg::SLOT_OUT_WIDTH-1:0]   out_slot_index,
  output logic [rrqs_pkg::PID_OUT_WIDTH-1:0]    out_task_pid,
  input  logic                                  cfg_wr_en,
  input  logic [rrqs_pkg::QUANTUM_WIDTH-1:0]    cfg_wr_data
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int QW = rrqs_pkg::QUANTUM_WIDTH;
  localparam int CW = rrqs_pkg::COUNT_WIDTH;
  localparam int EW = PID_WIDTH + QW + CW;
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CSCAN  = 3'd1;
  localparam logic [2:0] S_TCHK   = 3'd2;
  localparam logic [2:0] S_TSCAN  = 3'd3;
  localparam logic [2:0] S_TWR    = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [NUM_SLOTS-1:0] active_r, active_nxt;
  logic [SW-1:0]        cur_r, cur_nxt;
  logic                 have_cur_r, have_cur_nxt;
  logic [PID_WIDTH-1:0] next_pid_r, next_pid_nxt;
  logic [QW-1:0]        max_q_r;
  logic [SW-1:0]        idx_r, idx_nxt;
  logic [SW-1:0]        cnt_r, cnt_nxt;
  logic [QW-1:0]        req_q_r, req_q_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic [rrqs_pkg::STATUS_WIDTH-1:0]   out_status_r, out_status_nxt;
  logic [rrqs_pkg::SLOT_OUT_WIDTH-1:0] out_slot_r, out_slot_nxt;
  logic [rrqs_pkg::PID_OUT_WIDTH-1:0]  out_pid_r, out_pid_nxt;

  logic          ram_we;
  logic [SW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [PID_WIDTH-1:0] rd_pid;
  logic [QW-1:0]        rd_q;
  logic [CW-1:0]        rd_cnt;
  logic [SW-1:0]        idx_inc;
  logic [SW-1:0]        cur_inc;
  logic                 accept;

  rrqs_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Slot 0 is the idle task: pid 0 and quantum 1 regardless of the table.
  // When ram_rdata is used (S_TCHK, S_TWR), idx_r names the entry it holds.
  assign rd_pid  = (idx_r == '0) ? '0 : ram_rdata[EW-1:QW+CW];
  assign rd_q    = (idx_r == '0) ? rrqs_pkg::IDLE_QUANTUM : ram_rdata[QW+CW-1:CW];
  assign rd_cnt  = ram_rdata[CW-1:0];
  assign idx_inc = (idx_r == LAST_SLOT) ? '0 : idx_r + 1'b1;
  assign cur_inc = (cur_r == LAST_SLOT) ? '0 : cur_r + 1'b1;
  assign accept  = start && !busy;

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    cur_nxt        = cur_r;
    have_cur_nxt   = have_cur_r;
    next_pid_nxt   = next_pid_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    req_q_nxt      = req_q_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_pid_nxt    = out_pid_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = '0;
    ram_raddr      = idx_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == rrqs_pkg::CMD_CREATE) begin
            req_q_nxt = (in_time_slot > rrqs_pkg::REQ_WIDTH'(max_q_r)) ?
                        max_q_r : in_time_slot[QW-1:0];
            idx_nxt   = '0;
            state_nxt = S_CSCAN;
          end else if (!have_cur_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = rrqs_pkg::ST_NONE;
            out_slot_nxt   = '0;
            out_pid_nxt    = '0;
          end else begin
            ram_raddr = cur_r;
            idx_nxt   = cur_r;
            state_nxt = S_TCHK;
          end
        end
      end

      S_CSCAN: begin
        if (!active_r[idx_r]) begin
          ram_we              = 1'b1;
          ram_waddr           = idx_r;
          ram_wdata           = {next_pid_r, req_q_r, CW'(0)};
          active_nxt[idx_r]   = 1'b1;
          next_pid_nxt        = next_pid_r + 1'b1;
          if (!have_cur_r) begin
            have_cur_nxt = 1'b1;
            cur_nxt      = idx_r;
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = rrqs_pkg::ST_OK;
          out_slot_nxt   = rrqs_pkg::SLOT_OUT_WIDTH'(idx_r);
          out_pid_nxt    = rrqs_pkg::PID_OUT_WIDTH'(next_pid_r);
          state_nxt      = S_IDLE;
        end else if (idx_r == LAST_SLOT) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rrqs_pkg::ST_FULL;
          out_slot_nxt   = '0;
          out_pid_nxt    = '0;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt = idx_inc;
        end
      end

      S_TCHK: begin
        // ram_rdata holds the current slot's entry
        if (rd_cnt < CW'(rd_q) && active_r[cur_r]) begin
          ram_we         = 1'b1;
          ram_waddr      = cur_r;
          ram_wdata      = {ram_rdata[EW-1:CW],
                            (rd_cnt < rrqs_pkg::COUNT_TOP) ? rd_cnt + 1'b1 : rd_cnt};
          out_valid_nxt  = 1'b1;
          out_status_nxt = rrqs_pkg::ST_OK;
          out_slot_nxt   = rrqs_pkg::SLOT_OUT_WIDTH'(cur_r);
          out_pid_nxt    = rrqs_pkg::PID_OUT_WIDTH'(rd_pid);
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt   = cur_inc;
          cnt_nxt   = '0;
          state_nxt = S_TSCAN;
        end
      end

      S_TSCAN: begin
        if (idx_r != cur_r && idx_r != '0 && active_r[idx_r]) begin
          ram_raddr = idx_r;
          state_nxt = S_TWR;
        end else if (cnt_r == LAST_SLOT) begin
          // nothing else runnable: stay on current if active, else fall to idle
          idx_nxt   = active_r[cur_r] ? cur_r : '0;
          ram_raddr = idx_nxt;
          state_nxt = S_TWR;
        end else begin
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_TWR: begin
        // newly chosen: count restarts at zero, then this tick adds one
        ram_we         = 1'b1;
        ram_waddr      = idx_r;
        ram_wdata      = {rd_pid, rd_q, CW'(1)};
        cur_nxt        = idx_r;
        out_valid_nxt  = 1'b1;
        out_status_nxt = rrqs_pkg::ST_OK;
        out_slot_nxt   = rrqs_pkg::SLOT_OUT_WIDTH'(idx_r);
        out_pid_nxt    = rrqs_pkg::PID_OUT_WIDTH'(rd_pid);
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= NUM_SLOTS'(1);
      cur_r       <= '0;
      have_cur_r  <= 1'b0;
      next_pid_r  <= PID_WIDTH'(1);
      max_q_r     <= rrqs_pkg::MAX_QUANTUM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      cur_r       <= cur_nxt;
      have_cur_r  <= have_cur_nxt;
      next_pid_r  <= next_pid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_q_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    req_q_r      <= req_q_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_pid_r    <= out_pid_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;
  assign out_task_pid   = out_pid_r;

`ifndef NO_ASSERTIONS
  // the idle slot never leaves the table
  a_idle_slot_active: assert property (@(posedge clk) disable iff (!rst_n)
    active_r[0])
    else $error("idle slot lost its active bit");

  // a full table answers with slot 0 and pid 0
  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rrqs_pkg::ST_FULL |-> out_slot_index == '0 && out_task_pid == '0)
    else $error("table-full word carries a slot or pid");

  // a current task only appears through a create
  a_first_current: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(have_cur_r) |-> $past(state_r) == S_CSCAN)
    else $error("current task set outside a create");

  // a tick's scan only runs once a current task exists
  a_scan_has_current: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TCHK || state_r == S_TSCAN || state_r == S_TWR |-> have_cur_r)
    else $error("tick scan without a current task");
`endif

endmodule
